/* sv/dttfp_pkg.sv */
// Shared status type, constants and the power-of-ten lookup function for the decimal text parser.
`timescale 1ns / 1ps
package dttfp_pkg;

   localparam int INT_BITS        = 32;
   localparam int FRAC_BITS       = 16;
   localparam int VALUE_W         = INT_BITS + FRAC_BITS;
   localparam int MAX_FRAC_DIGITS = 9;
   // 10^9 - 1 fits in 30 bits
   localparam int FRAC_ACC_W      = 30;
   localparam int FCNT_W          = 4;
   localparam int QCNT_W          = $clog2(FRAC_BITS);

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_DOT  = 8'h2e;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_INVALID  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // 10^k for the number of fraction digits kept
   function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FCNT_W-1:0] k);
      logic [FRAC_ACC_W-1:0] p;
      begin
         case (k)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
         endcase
         return p;
      end
   endfunction

endpackage

/* sv/decimal_text_to_fixed_point.sv */
// Top level: ASCII decimal string to unsigned Q32.16 parser.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one character per transfer: req_char_code, req_has_char
//   (0 for an ignored item or a bare end marker) and req_is_last (end of the string).
//   rsp_* carries one result per string: rsp_status (ok, empty, invalid,
//   overflow) and rsp_value in unsigned Q32.16.
// Flow:
//   A character that does not end the string updates the integer and
//   fraction accumulators by shift-and-add, so a string streams in at
//   one character per cycle.
//   The last character of a valid string starts a restoring divider that
//   produces one fraction bit per cycle (one shared compare and subtract
//   unit), then the output state loads the output register, waiting while
//   the register still holds a result that rsp_ready has not taken. Strings
//   that end empty, invalid or saturated skip the divider.
//   req_ready is low from the last character until the result is loaded.
// Reset: synchronous, active high; clears the accumulators, the sequencer
//   and rsp_valid. No clearing pass is needed.
// Stall: a result waits in the output register while rsp_ready is low; the
//   next string's characters are still taken meanwhile, but that string's
//   result holds in the sequencer until the register frees up.
module decimal_text_to_fixed_point (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_char_code,
   input  logic                           req_has_char,
   input  logic                           req_is_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [dttfp_pkg::VALUE_W-1:0]  rsp_value
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_OUT
   } state_type;

   // Parse accumulators
   logic [dttfp_pkg::INT_BITS-1:0]   int_acc_ff, int_acc_in;
   logic [dttfp_pkg::FRAC_ACC_W-1:0] frac_acc_ff, frac_acc_in;
   logic [dttfp_pkg::FCNT_W-1:0]     frac_cnt_ff, frac_cnt_in;
   logic                             dot_ff, dot_in;
   logic                             any_ff, any_in;
   dttfp_pkg::status_type            err_ff, err_in;

   // Sequencer, divider and output
   state_type                        state_ff;
   logic [dttfp_pkg::FRAC_ACC_W-1:0] rem_ff;
   logic [dttfp_pkg::FRAC_ACC_W-1:0] div_ff;
   logic [dttfp_pkg::FRAC_BITS-1:0]  quo_ff;
   logic [dttfp_pkg::QCNT_W-1:0]     qcnt_ff;
   logic [dttfp_pkg::INT_BITS-1:0]   res_int_ff;
   dttfp_pkg::status_type            res_status_ff;
   dttfp_pkg::status_type            fin_status;
   logic                             rsp_valid_ff;
   logic [1:0]                       rsp_status_ff;
   logic [dttfp_pkg::VALUE_W-1:0]    rsp_value_ff;

   logic                             take;
   logic                             take_last;
   logic                             is_digit;
   logic                             is_dot;
   logic [3:0]                       digit;
   logic [dttfp_pkg::INT_BITS+3:0]   int_prod;
   logic                             int_ovf;
   logic [dttfp_pkg::FRAC_ACC_W+3:0] frac_prod;
   logic [dttfp_pkg::FRAC_ACC_W:0]   rem_shift;
   logic                             rem_ge;
   logic                             out_free;

   assign req_ready  = (state_ff == S_IDLE);
   assign take       = req_valid && req_ready;
   assign take_last  = take && req_is_last;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign is_digit = (req_char_code >= dttfp_pkg::CHAR_ZERO) &&
                     (req_char_code <= dttfp_pkg::CHAR_NINE);
   assign is_dot   = (req_char_code == dttfp_pkg::CHAR_DOT);
   assign digit    = req_char_code[3:0];

   // acc * 10 + d by shift and add; overflow when the top bits are set
   assign int_prod  = {1'b0, int_acc_ff, 3'b000} + {3'b000, int_acc_ff, 1'b0}
                    + {{dttfp_pkg::INT_BITS{1'b0}}, digit};
   assign int_ovf   = |int_prod[dttfp_pkg::INT_BITS+3:dttfp_pkg::INT_BITS];
   assign frac_prod = {1'b0, frac_acc_ff, 3'b000} + {3'b000, frac_acc_ff, 1'b0}
                    + {{dttfp_pkg::FRAC_ACC_W{1'b0}}, digit};

   // Character step
   always_comb begin
      int_acc_in  = int_acc_ff;
      frac_acc_in = frac_acc_ff;
      frac_cnt_in = frac_cnt_ff;
      dot_in      = dot_ff;
      any_in      = any_ff;
      err_in      = err_ff;
      if (take && req_has_char) begin
         any_in = 1'b1;
         if (is_dot && !dot_ff) begin
            dot_in = 1'b1;
         end else if (!is_digit) begin
            err_in = dttfp_pkg::ST_INVALID;
         end else if (!dot_ff) begin
            if (int_ovf) begin
               int_acc_in = '1;
               if (err_ff == dttfp_pkg::ST_OK) begin
                  err_in = dttfp_pkg::ST_OVERFLOW;
               end
            end else begin
               int_acc_in = int_prod[dttfp_pkg::INT_BITS-1:0];
            end
         end else if (frac_cnt_ff < dttfp_pkg::FCNT_W'(dttfp_pkg::MAX_FRAC_DIGITS)) begin
            frac_acc_in = frac_prod[dttfp_pkg::FRAC_ACC_W-1:0];
            frac_cnt_in = frac_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (!any_in) begin
         fin_status = dttfp_pkg::ST_EMPTY;
      end else begin
         fin_status = err_in;
      end
   end

   // Hold the accumulators; clear them on reset or once the string ends
   always_ff @(posedge clock) begin
      if (reset || take_last) begin
         int_acc_ff  <= '0;
         frac_acc_ff <= '0;
         frac_cnt_ff <= '0;
         dot_ff      <= 1'b0;
         any_ff      <= 1'b0;
         err_ff      <= dttfp_pkg::ST_OK;
      end else begin
         int_acc_ff  <= int_acc_in;
         frac_acc_ff <= frac_acc_in;
         frac_cnt_ff <= frac_cnt_in;
         dot_ff      <= dot_in;
         any_ff      <= any_in;
         err_ff      <= err_in;
      end
   end

   // One restoring step: shift the remainder, compare, subtract
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken result unless the output state reloads the register
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (take_last) begin
                  res_status_ff <= fin_status;
                  res_int_ff    <= int_acc_in;
                  rem_ff        <= frac_acc_in;
                  div_ff        <= dttfp_pkg::pow10(frac_cnt_in);
                  quo_ff        <= '0;
                  qcnt_ff       <= '0;
                  if (fin_status == dttfp_pkg::ST_OK) begin
                     state_ff <= S_DIV;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_DIV: begin
               if (rem_ge) begin
                  rem_ff <= rem_shift[dttfp_pkg::FRAC_ACC_W-1:0]
                          - div_ff;
               end else begin
                  rem_ff <= rem_shift[dttfp_pkg::FRAC_ACC_W-1:0];
               end
               quo_ff  <= {quo_ff[dttfp_pkg::FRAC_BITS-2:0], rem_ge};
               qcnt_ff <= qcnt_ff + 1'b1;
               if (qcnt_ff == dttfp_pkg::QCNT_W'(dttfp_pkg::FRAC_BITS - 1)) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  case (res_status_ff)
                     dttfp_pkg::ST_OK:       rsp_value_ff <= {res_int_ff, quo_ff};
                     dttfp_pkg::ST_OVERFLOW: rsp_value_ff <= '1;
                     default:                rsp_value_ff <= '0;
                  endcase
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // The divider remainder always stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   // A result only appears out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   // Ending a string leaves the accumulators cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take_last |=> (int_acc_ff == '0) && !any_ff && !dot_ff && (frac_cnt_ff == '0))
      else $error("accumulators not cleared after last character");

   // Failed strings carry zero, saturated ones all ones
   a_value_by_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_status_ff == dttfp_pkg::ST_OK) ||
          ((rsp_status_ff == dttfp_pkg::ST_OVERFLOW) && (rsp_value_ff == '1)) ||
          (rsp_value_ff == '0)))
      else $error("result value does not match its status");

   // No character taken while a result is being finished
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      take_last |=> !req_ready)
      else $error("input taken while finishing a result");

endmodule

/* bench/decimal_parse_checker.sv */
// Checker for the decimal text parser: tracks transfers, predicts each number, compares results.
`timescale 1ns / 1ps
module decimal_parse_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_char_code,
   input  logic                          req_has_char,
   input  logic                          req_is_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_status,
   input  logic [dttfp_pkg::VALUE_W-1:0] rsp_value,
   output int                            mismatch_count,
   output int                            pending_count
);

   typedef struct packed {
      logic [1:0]                    status;
      logic [dttfp_pkg::VALUE_W-1:0] value;
   } number_type;

   number_type expected_numbers[$];

   // parse state of the string in flight
   logic [dttfp_pkg::INT_BITS-1:0]   int_part;
   logic [dttfp_pkg::FRAC_ACC_W-1:0] frac_digits;
   logic [dttfp_pkg::FCNT_W-1:0]     frac_kept;
   logic                             dot_seen;
   logic                             char_seen;
   dttfp_pkg::status_type            parse_error;

   task automatic clear_number();
      int_part    = '0;
      frac_digits = '0;
      frac_kept   = '0;
      dot_seen    = 1'b0;
      char_seen   = 1'b0;
      parse_error = dttfp_pkg::ST_OK;
   endtask

   always @(posedge clock) begin : track
      number_type  got;
      number_type  want;
      logic [63:0] digit;
      logic [63:0] divisor;
      logic [63:0] scaled;
      if (reset) begin
         clear_number();
         expected_numbers.delete();
         mismatch_count = 0;
      end else begin
         // compare first: a result never belongs to a string ending on this edge
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.value  = rsp_value;
            if (expected_numbers.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: status %0d value %h", got.status, got.value);
               mismatch_count++;
            end else begin
               want = expected_numbers.pop_front();
               if (got.status !== want.status || got.value !== want.value) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected status %0d value %h, got status %0d value %h",
                              want.status, want.value, got.status, got.value);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_has_char) begin
               char_seen = 1'b1;
               if (req_char_code == dttfp_pkg::CHAR_DOT && !dot_seen) begin
                  dot_seen = 1'b1;
               end else if (req_char_code < dttfp_pkg::CHAR_ZERO ||
                            req_char_code > dttfp_pkg::CHAR_NINE) begin
                  parse_error = dttfp_pkg::ST_INVALID;
               end else begin
                  digit = 64'(req_char_code - dttfp_pkg::CHAR_ZERO);
                  if (!dot_seen) begin
                     // saturate the integer part; invalid keeps priority
                     if (64'(int_part) >
                         (((64'd1 << dttfp_pkg::INT_BITS) - 1) - digit) / 10) begin
                        int_part = '1;
                        if (parse_error == dttfp_pkg::ST_OK)
                           parse_error = dttfp_pkg::ST_OVERFLOW;
                     end else begin
                        int_part = dttfp_pkg::INT_BITS'(64'(int_part) * 10 + digit);
                     end
                  end else if (frac_kept < dttfp_pkg::MAX_FRAC_DIGITS) begin
                     frac_digits = dttfp_pkg::FRAC_ACC_W'(64'(frac_digits) * 10 + digit);
                     frac_kept++;
                  end
               end
            end
            if (req_is_last) begin
               want.value = '0;
               if (!char_seen) begin
                  want.status = dttfp_pkg::ST_EMPTY;
               end else if (parse_error == dttfp_pkg::ST_INVALID) begin
                  want.status = dttfp_pkg::ST_INVALID;
               end else if (parse_error == dttfp_pkg::ST_OVERFLOW) begin
                  want.status = dttfp_pkg::ST_OVERFLOW;
                  want.value  = '1;
               end else begin
                  divisor = 64'd1;
                  for (int i = 0; i < frac_kept; i++)
                     divisor = divisor * 10;
                  scaled      = (64'(frac_digits) << dttfp_pkg::FRAC_BITS) / divisor;
                  want.status = dttfp_pkg::ST_OK;
                  want.value  = dttfp_pkg::VALUE_W'(
                                   (64'(int_part) << dttfp_pkg::FRAC_BITS) | scaled);
               end
               expected_numbers.push_back(want);
               clear_number();
            end
         end
      end
      pending_count = expected_numbers.size();
   end

endmodule

/* bench/tb_top.sv */
// Testbench top for the decimal text parser: clock, reset, stimulus, receiver pattern, verdict.
`timescale 1ns / 1ps
module tb_top;

   // Longest legal stretch without a transfer is the receiver hold-off plus
   // one divider pass; the watchdog limit sits well above that.
   localparam int STALL_LIMIT = 4000;
   localparam int ITEM_TARGET = 1800;
   localparam int HOLD_START  = 2500;
   localparam int HOLD_CYCLES = 600;
   // drain margin after the last result: one divider pass and then some
   localparam int DRAIN_CYCLES = 40;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_char_code = '0;
   logic                          req_has_char  = 1'b0;
   logic                          req_is_last   = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic [1:0]                    rsp_status;
   logic [dttfp_pkg::VALUE_W-1:0] rsp_value;

   int mismatch_count;
   int pending_count;

   // sender state
   int         burst_left   = 0;
   bit         sender_idles = 1'b1;
   int         items_sent   = 0;
   logic [7:0] text[$];

   always #6 clock = ~clock;

   decimal_text_to_fixed_point dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_has_char  (req_has_char),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value     (rsp_value)
   );

   decimal_parse_checker number_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_has_char   (req_has_char),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_value      (rsp_value),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Offer one item and hold it until the transfer. Called at a falling edge,
   // returns at the falling edge after the transfer. Between bursts, drop
   // valid for a random gap; valid stays high from one item to the next
   // inside a burst, so it gets one assignment per step.
   task automatic send_item(input logic [7:0] code, input logic has_char, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (!sender_idles || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_has_char  <= has_char;
      req_is_last   <= last;
      // ready is sampled at the rising edge, before the block updates it
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Send the queued text as one string, ending either on its last character
   // or on a bare end marker. Sprinkle ignored items (no character, no end).
   task automatic send_text(input bit bare_end);
      for (int i = 0; i < text.size(); i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(text[i], 1'b1, !bare_end && i == text.size() - 1);
         items_sent++;
      end
      if (bare_end) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
   endtask

   task automatic add_digits(input int n);
      repeat (n) text.push_back(dttfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   // Well-formed number: short parts mostly, now and then an integer part
   // long enough to overflow or a fraction longer than the digits kept.
   task automatic make_number();
      int int_len;
      int frac_len;
      int_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 4);
      add_digits(int_len);
      if ($urandom_range(0, 9) < 7) begin
         text.push_back(dttfp_pkg::CHAR_DOT);
         frac_len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
         add_digits(frac_len);
      end
   endtask

   // Stimulus: reset, directed strings, then random strings until the item
   // target is reached; drain and give the verdict.
   initial begin : stimulus
      int kind;
      bit bare_end;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty string: a bare end marker with nothing before it
      text.delete();
      send_text(1'b1);
      // only a dot
      push_str(".");
      send_text(1'b0);
      // an ignored item, then a one-digit number
      send_item(8'hff, 1'b0, 1'b0);
      text.delete();
      push_str("7");
      send_text(1'b0);
      // second dot
      text.delete();
      push_str("..");
      send_text(1'b0);
      // extremes of the character code, both invalid
      text.delete();
      text.push_back(8'hff);
      send_text(1'b0);
      text.delete();
      text.push_back(8'h00);
      send_text(1'b0);
      // one past the largest integer part
      text.delete();
      push_str("4294967296");
      send_text(1'b0);
      // ordinary number closed by a bare end marker
      text.delete();
      push_str("12.375");
      send_text(1'b1);

      while (items_sent < ITEM_TARGET) begin
         // flip between idling and back-to-back stretches now and then
         if ($urandom_range(0, 29) == 0)
            sender_idles = !sender_idles;
         text.delete();
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            make_number();
         end else if (kind < 70) begin
            // around the top of the integer range
            push_str("429496729");
            add_digits(1);
            if ($urandom_range(0, 2) == 0)
               add_digits(1);
            if ($urandom_range(0, 1) == 0)
               push_str(".5");
         end else if (kind < 88) begin
            // broken number: an extra dot or a random byte
            make_number();
            if ($urandom_range(0, 1) == 0)
               text.insert($urandom_range(0, text.size()), dttfp_pkg::CHAR_DOT);
            else if (text.size() != 0)
               text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            else
               text.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 95) begin
            // noise
            repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(0, 255)));
         end
         bare_end = (text.size() == 0) || ($urandom_range(0, 4) == 0);
         send_text(bare_end);
      end
      req_valid <= 1'b0;

      // drain; the watchdog covers a result that never comes
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: a random mode per phase, plus one long hold-off while the
   // sender keeps offering, so the block backs up and stalls its input.
   initial begin : receiver
      int          rx_cycle;
      int          phase_left;
      int          period;
      rx_mode_type mode;
      rx_cycle   = 0;
      phase_left = 0;
      period     = 1;
      mode       = RX_ALWAYS;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (phase_left == 0) begin
            mode       = rx_mode_type'($urandom_range(0, 3));
            period     = $urandom_range(1, 8);
            phase_left = $urandom_range(50, 250);
         end
         phase_left--;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS:   rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
               RX_PERIODIC: rsp_ready <= (rx_cycle % (period + 1) == 0);
               default:     rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule

/* decimal_text_to_fixed_point.f */
sv/dttfp_pkg.sv
sv/decimal_text_to_fixed_point.sv
bench/decimal_parse_checker.sv
bench/tb_top.sv
